### design/pip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg: shared types and constants for the point-in-polygon test
// Opcodes, fixed field widths and the control word that travels along the
// cell chain together with each query.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam int VIDX_W = 4;
  localparam int CFG_W  = 5;
  localparam int CNT_W  = 5;
  localparam int OUT_W  = 8;

  typedef struct packed {
    logic             valid;
    logic             pend;
    logic             dpos;
    logic [CNT_W-1:0] count;
  } pip_ctl_t;

endpackage

### design/pip_hit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_hit: crossing decision for one edge
// Compares the two registered cross products, direction set by the sign of
// the edge's y difference.
// ----------------------------------------------------------------------------
module pip_hit #(
  parameter int PW = 34
) (
  input  logic                 pend,
  input  logic                 dpos,
  input  logic signed [PW-1:0] lhs,
  input  logic signed [PW-1:0] rhs,
  output logic                 hit
);

  always_comb begin
    if (dpos) begin
      hit = pend && (lhs < rhs);
    end else begin
      hit = pend && (rhs < lhs);
    end
  end

endmodule

### design/pip_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_cell: one vertex slot of the polygon chain
// Holds vertex K, forms the cross products for the edge from the previous
// vertex to this one, and resolves the products handed in by its neighbor.
// ----------------------------------------------------------------------------
module pip_cell import pip_pkg::*; #(
  parameter int W  = 16,
  parameter int NW = 5,
  parameter int K  = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     wr_en,
  input  logic signed [W-1:0]      wr_x,
  input  logic signed [W-1:0]      wr_y,
  input  logic [NW-1:0]            n_eff,
  input  pip_ctl_t                 in_ctl,
  input  logic signed [W-1:0]      in_px,
  input  logic signed [W-1:0]      in_py,
  input  logic signed [W-1:0]      in_xj,
  input  logic signed [W-1:0]      in_yj,
  input  logic signed [2*W+1:0]    in_lhs,
  input  logic signed [2*W+1:0]    in_rhs,
  output logic signed [W-1:0]      vx,
  output logic signed [W-1:0]      vy,
  output pip_ctl_t                 out_ctl,
  output logic signed [W-1:0]      out_px,
  output logic signed [W-1:0]      out_py,
  output logic signed [2*W+1:0]    out_lhs,
  output logic signed [2*W+1:0]    out_rhs
);

  localparam int DW = W + 1;
  localparam int PW = 2 * W + 2;

  logic                 hit_in;
  logic                 active;
  logic                 straddle;
  logic signed [DW-1:0] dy;
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dxl;
  logic signed [DW-1:0] dyp;
  logic signed [PW-1:0] lhs_next;
  logic signed [PW-1:0] rhs_next;

  pip_hit #(.PW(PW)) u_hit (
    .pend (in_ctl.pend),
    .dpos (in_ctl.dpos),
    .lhs  (in_lhs),
    .rhs  (in_rhs),
    .hit  (hit_in)
  );

  always_comb begin
    active   = n_eff > NW'(K);
    straddle = (vy > in_py) != (in_yj > in_py);
    dy       = DW'(in_yj) - DW'(vy);
    dx       = DW'(in_xj) - DW'(vx);
    dxl      = DW'(in_px) - DW'(vx);
    dyp      = DW'(in_py) - DW'(vy);
    lhs_next = dxl * dy;
    rhs_next = dx * dyp;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vx <= wr_x;
      vy <= wr_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else if (en) begin
      out_ctl.valid <= in_ctl.valid;
      out_ctl.pend  <= in_ctl.valid && active && straddle;
      out_ctl.dpos  <= dy > 0;
      out_ctl.count <= in_ctl.count + CNT_W'(hit_in);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_px  <= in_px;
      out_py  <= in_py;
      out_lhs <= lhs_next;
      out_rhs <= rhs_next;
    end
  end

endmodule

### design/point_in_polygon_test.sv
`timescale 1ns / 1ps
// A query walks the cell chain one vertex cell per cycle unless the output stalls, and
//   its result shows on m_tvalid after the output register; only one query is in flight.
//   Vertex stores are taken one per cycle while no query is in flight.
// Reset (rst, synchronous): clears vertex_count, the chain control and the output;
//   vertex slots keep whatever they held and must be written before use.
// ----------------------------------------------------------------------------
// point_in_polygon_test: crossing-number point-in-polygon test
// Stores polygon vertices in a chain of cells and counts the edges crossed by
// a rightward ray from each query point; inside is the parity of that count.
// ----------------------------------------------------------------------------
module point_in_polygon_test import pip_pkg::*; #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_WIDTH  = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       cfg_wr_en,
  input  logic [CFG_W-1:0]                           cfg_wr_data,
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  // vertex_index, vertex_x, vertex_y, point_x, point_y, zero fill
  input  logic [((VIDX_W+4*COORD_WIDTH+7)/8)*8-1:0]  s_tdata,
  // op
  input  logic                                       s_tuser,
  output logic                                       m_tvalid,
  input  logic                                       m_tready,
  // inside_res, crossing_count, zero fill
  output logic [OUT_W-1:0]                           m_tdata
);

  localparam int W    = COORD_WIDTH;
  localparam int N    = MAX_VERTICES;
  localparam int PW   = 2 * W + 2;
  localparam int IW   = $clog2(N);
  localparam int NCW  = $clog2(N + 1);
  localparam int NW   = (NCW > CFG_W) ? NCW : CFG_W;

  logic [CFG_W-1:0]       vertex_count;
  logic [NW-1:0]          n_ext;
  logic [NW-1:0]          n_eff;
  logic [IW-1:0]          last_idx;

  logic [VIDX_W-1:0]      in_vidx;
  logic signed [W-1:0]    in_vx;
  logic signed [W-1:0]    in_vy;
  logic signed [W-1:0]    in_px;
  logic signed [W-1:0]    in_py;

  logic                   acc;
  logic                   acc_store;
  logic                   acc_query;
  logic                   busy;
  logic                   adv;
  logic                   load;
  logic                   hit_last;
  logic [CNT_W-1:0]       count_final;

  pip_ctl_t               inj_ctl;
  logic signed [W-1:0]    inj_px;
  logic signed [W-1:0]    inj_py;
  logic signed [W-1:0]    inj_xj;
  logic signed [W-1:0]    inj_yj;
  logic signed [PW-1:0]   zero_prod;

  logic signed [W-1:0]    vx_all  [N];
  logic signed [W-1:0]    vy_all  [N];
  pip_ctl_t               st_ctl  [N];
  logic signed [W-1:0]    st_px   [N];
  logic signed [W-1:0]    st_py   [N];
  logic signed [PW-1:0]   st_lhs  [N];
  logic signed [PW-1:0]   st_rhs  [N];

  assign in_vidx   = s_tdata[VIDX_W-1:0];
  assign in_vx     = s_tdata[VIDX_W +: W];
  assign in_vy     = s_tdata[VIDX_W+W +: W];
  assign in_px     = s_tdata[VIDX_W+2*W +: W];
  assign in_py     = s_tdata[VIDX_W+3*W +: W];

  assign s_tready  = !busy;
  assign acc       = s_tvalid && s_tready;
  assign acc_store = acc && (s_tuser == OP_STORE);
  assign acc_query = acc && (s_tuser == OP_QUERY);
  assign zero_prod = '0;

  always_comb begin
    n_ext = NW'(vertex_count);
    if (n_ext > NW'(N)) begin
      n_eff = NW'(N);
    end else begin
      n_eff = n_ext;
    end
    if (n_eff == '0) begin
      last_idx = '0;
    end else begin
      last_idx = IW'(n_eff - NW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_wr_en) begin
      vertex_count <= cfg_wr_data;
    end
  end

  // Inject the query with the last vertex as the wrap-around edge start
  always_ff @(posedge clk) begin
    if (rst) begin
      inj_ctl <= '0;
    end else if (acc_query) begin
      inj_ctl <= '{valid: 1'b1, pend: 1'b0, dpos: 1'b0, count: '0};
    end else if (adv) begin
      inj_ctl.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_query) begin
      inj_px <= in_px;
      inj_py <= in_py;
      inj_xj <= vx_all[last_idx];
      inj_yj <= vy_all[last_idx];
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    logic wr_en;
    assign wr_en = acc_store && (32'(in_vidx) == k);
    if (k == 0) begin : g_head
      pip_cell #(.W(W), .NW(NW), .K(k)) u_cell (
        .clk     (clk),
        .rst     (rst),
        .en      (adv),
        .wr_en   (wr_en),
        .wr_x    (in_vx),
        .wr_y    (in_vy),
        .n_eff   (n_eff),
        .in_ctl  (inj_ctl),
        .in_px   (inj_px),
        .in_py   (inj_py),
        .in_xj   (inj_xj),
        .in_yj   (inj_yj),
        .in_lhs  (zero_prod),
        .in_rhs  (zero_prod),
        .vx      (vx_all[k]),
        .vy      (vy_all[k]),
        .out_ctl (st_ctl[k]),
        .out_px  (st_px[k]),
        .out_py  (st_py[k]),
        .out_lhs (st_lhs[k]),
        .out_rhs (st_rhs[k])
      );
    end else begin : g_body
      pip_cell #(.W(W), .NW(NW), .K(k)) u_cell (
        .clk     (clk),
        .rst     (rst),
        .en      (adv),
        .wr_en   (wr_en),
        .wr_x    (in_vx),
        .wr_y    (in_vy),
        .n_eff   (n_eff),
        .in_ctl  (st_ctl[k-1]),
        .in_px   (st_px[k-1]),
        .in_py   (st_py[k-1]),
        .in_xj   (vx_all[k-1]),
        .in_yj   (vy_all[k-1]),
        .in_lhs  (st_lhs[k-1]),
        .in_rhs  (st_rhs[k-1]),
        .vx      (vx_all[k]),
        .vy      (vy_all[k]),
        .out_ctl (st_ctl[k]),
        .out_px  (st_px[k]),
        .out_py  (st_py[k]),
        .out_lhs (st_lhs[k]),
        .out_rhs (st_rhs[k])
      );
    end
  end

  pip_hit #(.PW(PW)) u_hit_last (
    .pend (st_ctl[N-1].pend),
    .dpos (st_ctl[N-1].dpos),
    .lhs  (st_lhs[N-1]),
    .rhs  (st_rhs[N-1]),
    .hit  (hit_last)
  );

  assign count_final = st_ctl[N-1].count + CNT_W'(hit_last);
  assign load        = st_ctl[N-1].valid && (!m_tvalid || m_tready);
  assign adv         = !st_ctl[N-1].valid || !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (acc_query) begin
      busy <= 1'b1;
    end else if (load) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {(OUT_W - CNT_W - 1)'(0), count_final, count_final[0]};
    end
  end

endmodule

### design/pip_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_checker: port-level checks for the point-in-polygon test
// Watches the request handshakes and the result word of the top level.
// ----------------------------------------------------------------------------
module pip_checker import pip_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             s_tuser,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_parity: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[0] == m_tdata[1])
    else $error("inside bit differs from crossing count parity");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == OP_QUERY) |=> !s_tready)
    else $error("request taken while a query is in flight");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result without a query in flight");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (.*);

### tb/sv/point_in_polygon_test_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test_test: self-checking bench for the point-in-polygon test
// Loads polygon vertices and query points over the stream port, takes each
// crossing count and inside bit from a directed row or an exact integer model,
// and compares every result in order. A directed table covers reset, extreme
// coordinates and vertex count saturation; random sets follow under several idle
// patterns, with one long receiver hold-off and drains before each count change.
// ----------------------------------------------------------------------------
module point_in_polygon_test_test;
  import pip_pkg::*;

  localparam int MAX_V      = 16;
  localparam int COORD_W    = 16;
  localparam int TDATA_W    = ((VIDX_W + 4 * COORD_W + 7) / 8) * 8;
  localparam int SETTLE     = 2 * (MAX_V + 2);
  localparam int HOLD_LEN   = 400;
  localparam int QUIET_MAX  = 4000;
  localparam int SET_LEN    = 20;
  localparam int SETS       = 8;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct {
    logic              op;
    logic [VIDX_W-1:0] idx;
    coord_t            vx;
    coord_t            vy;
    coord_t            px;
    coord_t            py;
    bit                typed;
    logic              exp_in;
    logic [CNT_W-1:0]  exp_cnt;
  } request_t;

  typedef struct {
    bit               cfg_set;
    logic [CFG_W-1:0] cfg_val;
    request_t         req;
  } directed_row_t;

  typedef struct {
    logic             in_poly;
    logic [CNT_W-1:0] count;
  } crossing_t;

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [CFG_W-1:0]   cfg_wr_data;
  logic               s_tvalid;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata;
  logic               s_tuser;
  logic               m_tvalid;
  logic               m_tready;
  logic [OUT_W-1:0]   m_tdata;

  coord_t    poly_x [MAX_V];
  coord_t    poly_y [MAX_V];
  int        poly_n;
  request_t  offered_requests [$];
  crossing_t expected_crossings [$];
  int        errors;
  int        quiet_cycles;
  int        send_idle_pct;
  int        stall_pct;
  bit        hold_req;

  directed_row_t dir_rows [26];

  point_in_polygon_test #(
    .MAX_VERTICES (MAX_V),
    .COORD_WIDTH  (COORD_W)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic crossing_t count_crossings(coord_t qx, coord_t qy);
    crossing_t res;
    int        n;
    int        i;
    int        j;
    int        hits;
    longint    xi, yi, xj, yj, dy, lhs, rhs;
    bit        hit;
    n    = (poly_n > MAX_V) ? MAX_V : poly_n;
    j    = (n == 0) ? 0 : n - 1;
    hits = 0;
    for (i = 0; i < n; i++) begin
      xi = poly_x[i];
      yi = poly_y[i];
      xj = poly_x[j];
      yj = poly_y[j];
      if ((yi > qy) != (yj > qy)) begin
        dy  = yj - yi;
        lhs = (longint'(qx) - xi) * dy;
        rhs = (xj - xi) * (longint'(qy) - yi);
        hit = (dy > 0) ? (lhs < rhs) : (rhs < lhs);
        if (hit) hits++;
      end
      j = i;
    end
    res.in_poly = hits[0];
    res.count   = hits[CNT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin : monitor
    request_t  req;
    crossing_t got;
    crossing_t want;
    quiet_cycles++;
    if (!rst && s_tvalid && s_tready) begin
      quiet_cycles = 0;
      if (offered_requests.size() == 0) begin
        report_mismatch("request accepted while none offered", 0, 0);
      end else begin
        req = offered_requests.pop_front();
        if (req.op == OP_STORE) begin
          poly_x[req.idx] = req.vx;
          poly_y[req.idx] = req.vy;
        end else if (req.typed) begin
          want.in_poly = req.exp_in;
          want.count   = req.exp_cnt;
          expected_crossings.push_back(want);
        end else begin
          expected_crossings.push_back(count_crossings(req.px, req.py));
        end
      end
    end
    if (!rst && m_tvalid && m_tready) begin
      quiet_cycles = 0;
      got.in_poly = m_tdata[0];
      got.count   = m_tdata[CNT_W:1];
      if (expected_crossings.size() == 0) begin
        report_mismatch("result with no query waiting", got.count, 0);
      end else begin
        want = expected_crossings.pop_front();
        if (got.in_poly !== want.in_poly) begin
          report_mismatch("inside_res", got.in_poly, want.in_poly);
        end
        if (got.count !== want.count) report_mismatch("crossing_count", got.count, want.count);
      end
    end
    if (quiet_cycles >= QUIET_MAX) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : receiver
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(32) - 16);
      2: return coord_t'($urandom_range(6) - 3);
      default: begin
        case ($urandom_range(5))
          0: return coord_t'(-32768);
          1: return coord_t'(32767);
          2: return coord_t'(-1);
          3: return coord_t'(0);
          4: return coord_t'(1);
          default: return coord_t'($urandom);
        endcase
      end
    endcase
  endfunction

  function automatic directed_row_t store_row(int slot, int x, int y);
    directed_row_t r;
    r.cfg_set     = 1'b0;
    r.cfg_val     = '0;
    r.req.op      = OP_STORE;
    r.req.idx     = slot[VIDX_W-1:0];
    r.req.vx      = coord_t'(x);
    r.req.vy      = coord_t'(y);
    r.req.px      = coord_t'($urandom);
    r.req.py      = coord_t'($urandom);
    r.req.typed   = 1'b0;
    r.req.exp_in  = 1'b0;
    r.req.exp_cnt = '0;
    return r;
  endfunction

  function automatic directed_row_t query_row(bit cs, int cv, int x, int y, bit typed,
                                              bit e_in, int e_cnt);
    directed_row_t r;
    r.cfg_set     = cs;
    r.cfg_val     = cv[CFG_W-1:0];
    r.req.op      = OP_QUERY;
    r.req.idx     = VIDX_W'($urandom);
    r.req.vx      = coord_t'($urandom);
    r.req.vy      = coord_t'($urandom);
    r.req.px      = coord_t'(x);
    r.req.py      = coord_t'(y);
    r.req.typed   = typed;
    r.req.exp_in  = e_in;
    r.req.exp_cnt = e_cnt[CNT_W-1:0];
    return r;
  endfunction

  task automatic send_request(request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    offered_requests.push_back(r);
    s_tvalid <= 1'b1;
    s_tuser  <= r.op;
    s_tdata  <= {{(TDATA_W - VIDX_W - 4 * COORD_W){1'b0}}, r.py, r.px, r.vy, r.vx, r.idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (offered_requests.size() != 0 || expected_crossings.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_vertex_count(logic [CFG_W-1:0] v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    poly_n = int'(v);
  endtask

  task automatic run_set(bit hold);
    logic [CFG_W-1:0] cnt;
    int               mode;
    int               store_pct;
    int               k;
    request_t         r;
    case ($urandom_range(9))
      0: cnt = CFG_W'(0);
      1: cnt = CFG_W'(1);
      2: cnt = CFG_W'(2);
      3: cnt = CFG_W'(MAX_V);
      4: cnt = CFG_W'(31);
      5: cnt = CFG_W'($urandom_range(31));
      default: cnt = CFG_W'($urandom_range(3, MAX_V));
    endcase
    mode      = $urandom_range(3);
    store_pct = hold ? 5 : $urandom_range(10, 45);
    set_vertex_count(cnt);
    if (hold) hold_req = 1'b1;
    for (k = 0; k < SET_LEN; k++) begin
      r.op    = ($urandom_range(99) < store_pct) ? OP_STORE : OP_QUERY;
      r.idx   = VIDX_W'($urandom_range(MAX_V - 1));
      r.vx    = rand_coord(mode);
      r.vy    = rand_coord(mode);
      r.px    = rand_coord(mode);
      r.py    = rand_coord(mode);
      r.typed = 1'b0;
      r.exp_in  = 1'b0;
      r.exp_cnt = '0;
      if (r.op == OP_STORE) begin
        r.px = coord_t'($urandom);
        r.py = coord_t'($urandom);
      end else begin
        r.vx = coord_t'($urandom);
        r.vy = coord_t'($urandom);
      end
      send_request(r);
    end
  endtask

  initial begin : stimulus
    int p;
    int s;
    int k;
    errors        = 0;
    quiet_cycles  = 0;
    poly_n        = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    s_tvalid      = 1'b0;
    s_tuser       = 1'b0;
    s_tdata       = '0;
    for (k = 0; k < MAX_V; k++) begin
      poly_x[k] = '0;
      poly_y[k] = '0;
    end

    dir_rows = '{
      query_row(1'b0, 0, -32768, 32767, 1'b1, 1'b0, 0),
      store_row(0, -32768, -32768),
      store_row(1, 32767, -32768),
      store_row(2, 32767, 32767),
      store_row(3, -32768, 32767),
      query_row(1'b1, 1, 0, 0, 1'b1, 1'b0, 0),
      query_row(1'b1, 2, 0, -32768, 1'b0, 1'b0, 0),
      query_row(1'b1, 4, 0, 0, 1'b0, 1'b0, 0),
      query_row(1'b0, 0, -32768, -32768, 1'b0, 1'b0, 0),
      query_row(1'b0, 0, 32767, 32767, 1'b0, 1'b0, 0),
      query_row(1'b0, 0, 32767, 0, 1'b0, 1'b0, 0),
      query_row(1'b0, 0, -32768, 0, 1'b0, 1'b0, 0),
      store_row(4, 0, 0),
      store_row(5, 100, 100),
      store_row(6, -100, 100),
      store_row(7, 5, -3),
      store_row(8, 21845, -21846),
      store_row(9, -21846, 21845),
      store_row(10, 100, 0),
      store_row(11, -100, 0),
      store_row(12, 7, 100),
      store_row(13, -1, -1),
      store_row(14, 32767, 1),
      store_row(15, -32768, 1),
      query_row(1'b1, 31, 0, 0, 1'b0, 1'b0, 0),
      query_row(1'b1, MAX_V, 5, 0, 1'b0, 1'b0, 0)
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].cfg_set) set_vertex_count(dir_rows[k].cfg_val);
      send_request(dir_rows[k].req);
    end

    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 77; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 77; end
        default: begin send_idle_pct = 25; stall_pct = 25; end
      endcase
      for (s = 0; s < SETS; s++) run_set(p == 0 && s == 1);
    end

    wait_idle();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
